>>> hdl/lamc_pkg.sv
// ----------------------------------------------------------------------------
// lamc_pkg: shared types and codes for the linear actuator motion controller
// Holds the motion states, event codes, output codes, register indexes and
// the event transition function.
// ----------------------------------------------------------------------------
package lamc_pkg;

    localparam int TIMER_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 12;

    localparam int ACTION_W  = 4;
    localparam int VOLT_W    = 12;
    localparam int THRESH_W  = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_STOP_CURRENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_STOP_CURRENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INRUSH_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_VOLTAGE  = 3'd4;

    localparam logic [THRESH_W-1:0] UP_STOP_RESET   = 12'd2048;
    localparam logic [THRESH_W-1:0] DOWN_STOP_RESET = 12'd2048;
    localparam logic [15:0]         INRUSH_RESET    = 16'd500;
    localparam logic [15:0]         TIMEOUT_RESET   = 16'd5000;
    localparam logic [VOLT_W-1:0]   SHUTDOWN_RESET  = 12'd0;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_UP_BLANK = 3'd1,
        ST_DN_BLANK = 3'd2,
        ST_UP_CHECK = 3'd3,
        ST_DN_CHECK = 3'd4,
        ST_ERROR    = 3'd5
    } motion_state_t;

    typedef enum logic [3:0] {
        EV_TICK    = 4'd0,
        EV_STOP    = 4'd1,
        EV_CMD_UP  = 4'd2,
        EV_CMD_DN  = 4'd3,
        EV_SW_UP   = 4'd4,
        EV_SW_DN   = 4'd5,
        EV_SW_OFF  = 4'd6,
        EV_OVERCUR = 4'd7,
        EV_TOP     = 4'd8,
        EV_BOTTOM  = 4'd9,
        EV_TIMEOUT = 4'd10
    } event_t;

    localparam logic [1:0] DRIVE_OFF  = 2'd0;
    localparam logic [1:0] DRIVE_UP   = 2'd1;
    localparam logic [1:0] DRIVE_DOWN = 2'd2;

    localparam logic [2:0] STATUS_IDLE       = 3'd0;
    localparam logic [2:0] STATUS_UP         = 3'd1;
    localparam logic [2:0] STATUS_DOWN       = 3'd2;
    localparam logic [2:0] STATUS_STALL_UP   = 3'd3;
    localparam logic [2:0] STATUS_STALL_DOWN = 3'd4;

    localparam logic [1:0] REPLY_OK       = 2'd0;
    localparam logic [1:0] REPLY_AT_LIMIT = 2'd1;
    localparam logic [1:0] REPLY_LOW_VOLT = 2'd2;

    typedef struct packed {
        motion_state_t state;
        logic          stall_down;
        logic          kick;
        logic          start;
        logic          start_up;
    } event_result_t;

    function automatic event_result_t apply_event(
        input motion_state_t state,
        input logic          stall_down,
        input event_t        ev
    );
        event_result_t r;
        logic          up_dir;
        logic          dn_dir;
        r.state      = state;
        r.stall_down = stall_down;
        r.kick       = 1'b0;
        r.start      = 1'b0;
        r.start_up   = 1'b0;
        up_dir = (state == ST_UP_BLANK) || (state == ST_UP_CHECK);
        dn_dir = (state == ST_DN_BLANK) || (state == ST_DN_CHECK);
        if (state == ST_ERROR)
        begin
            if (ev == EV_STOP || ev == EV_TIMEOUT || ev == EV_SW_OFF)
                r.state = ST_IDLE;
            else if (ev == EV_CMD_UP || ev == EV_CMD_DN)
                r.kick = 1'b1;
        end
        else if (up_dir || dn_dir)
        begin
            if (ev == EV_STOP || ev == EV_SW_OFF || ev == EV_TIMEOUT
                || (up_dir && (ev == EV_TOP || ev == EV_CMD_DN || ev == EV_SW_DN))
                || (dn_dir && (ev == EV_BOTTOM || ev == EV_CMD_UP || ev == EV_SW_UP)))
                r.state = ST_IDLE;
            else if ((up_dir && ev == EV_CMD_UP) || (dn_dir && ev == EV_CMD_DN))
                r.kick = 1'b1;
            else if (ev == EV_OVERCUR && (state == ST_UP_CHECK || state == ST_DN_CHECK))
            begin
                r.stall_down = dn_dir;
                r.state      = ST_ERROR;
            end
        end
        else
        begin
            r.state = ST_IDLE;
            if (ev == EV_CMD_UP || ev == EV_CMD_DN || ev == EV_SW_UP || ev == EV_SW_DN)
            begin
                r.start    = 1'b1;
                r.start_up = (ev == EV_CMD_UP) || (ev == EV_SW_UP);
                r.state    = r.start_up ? ST_UP_BLANK : ST_DN_BLANK;
                r.kick     = (ev == EV_CMD_UP) || (ev == EV_CMD_DN);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/linear_actuator_motion_controller.sv
// ----------------------------------------------------------------------------
// linear_actuator_motion_controller
// A request's result is registered in the output register on acceptance.
// Throughput: one request per clock while the result is not held by m_axis_tready;
// the state update and the output decode sit between the input port and the result register.
// Reset: asynchronous, active low; idle, timers stopped, registers at defaults.
// ----------------------------------------------------------------------------
module linear_actuator_motion_controller #(
    parameter int TIMER_WIDTH  = lamc_pkg::TIMER_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = lamc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lamc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lamc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] top_switch, [1] bottom_switch, [13:2] line_voltage, [15:14] zero
    input  logic [lamc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [3:0] action
    input  logic [lamc_pkg::ACTION_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] drive, [4:2] status, [5] current_check_on, [17:6] stop_threshold,
    // [19:18] reply, [20] timeout_fired, [23:21] zero
    output logic [lamc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lamc_pkg::*;

    logic [THRESH_W-1:0]   up_stop_reg;
    logic [THRESH_W-1:0]   down_stop_reg;
    logic [15:0]           inrush_reg;
    logic [15:0]           timeout_reg;
    logic [VOLT_W-1:0]     shutdown_reg;

    motion_state_t         state_reg,     state_next;
    logic                  stall_reg,     stall_next;
    logic [TIMER_WIDTH-1:0] wd_count_reg, wd_count_next;
    logic                  wd_run_reg,    wd_run_next;
    logic [TIMER_WIDTH-1:0] blank_reg,    blank_next;
    logic [SAMPLE_WIDTH-1:0] thresh_reg,  thresh_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;

    logic                  in_fire;
    logic                  top_sw;
    logic                  bottom_sw;
    logic [VOLT_W-1:0]     volts;
    event_t                ev;
    event_result_t         er;
    logic                  use_event;
    logic [1:0]            reply;
    logic                  fired;
    logic [1:0]            drive;
    logic [2:0]            status;
    logic                  check_on;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign top_sw    = s_axis_tdata[0];
    assign bottom_sw = s_axis_tdata[1];
    assign volts     = s_axis_tdata[2 +: VOLT_W];
    assign ev        = event_t'(s_axis_tuser);
    assign er        = apply_event(state_reg, stall_reg, ev);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_stop_reg   <= UP_STOP_RESET;
            down_stop_reg <= DOWN_STOP_RESET;
            inrush_reg    <= INRUSH_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            shutdown_reg  <= SHUTDOWN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UP_STOP_CURRENT:   up_stop_reg   <= cfg_data[THRESH_W-1:0];
                REG_DOWN_STOP_CURRENT: down_stop_reg <= cfg_data[THRESH_W-1:0];
                REG_INRUSH_TICKS:      inrush_reg    <= cfg_data;
                REG_COMMAND_TIMEOUT:   timeout_reg   <= cfg_data;
                REG_SHUTDOWN_VOLTAGE:  shutdown_reg  <= cfg_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    // next state for one request
    always_comb
    begin
        state_next    = state_reg;
        stall_next    = stall_reg;
        wd_count_next = wd_count_reg;
        wd_run_next   = wd_run_reg;
        blank_next    = blank_reg;
        thresh_next   = thresh_reg;
        reply         = REPLY_OK;
        fired         = 1'b0;
        use_event     = 1'b0;

        unique case (ev)
            EV_TICK:
            begin
                if (wd_run_reg)
                begin
                    if (wd_count_reg <= TIMER_WIDTH'(1))
                    begin
                        // timeout drops every state to idle
                        fired         = 1'b1;
                        state_next    = ST_IDLE;
                        wd_count_next = TIMER_WIDTH'(timeout_reg);
                    end
                    else
                        wd_count_next = wd_count_reg - TIMER_WIDTH'(1);
                end
                if (blank_reg != '0)
                    blank_next = blank_reg - TIMER_WIDTH'(1);
                if (blank_next == '0)
                begin
                    if (state_next == ST_UP_BLANK)
                        state_next = ST_UP_CHECK;
                    else if (state_next == ST_DN_BLANK)
                        state_next = ST_DN_CHECK;
                end
            end
            EV_STOP, EV_CMD_UP, EV_CMD_DN:
            begin
                if (volts < shutdown_reg)
                    reply = REPLY_LOW_VOLT;
                else if (ev == EV_STOP)
                    use_event = 1'b1;
                else if ((ev == EV_CMD_UP && top_sw && !bottom_sw)
                         || (ev == EV_CMD_DN && bottom_sw && !top_sw))
                    reply = REPLY_AT_LIMIT;
                else
                begin
                    wd_run_next   = 1'b1;
                    wd_count_next = TIMER_WIDTH'(timeout_reg);
                    use_event     = 1'b1;
                end
            end
            EV_SW_UP, EV_SW_DN, EV_SW_OFF, EV_OVERCUR, EV_TOP, EV_BOTTOM:
                use_event = 1'b1;
            default: ;
        endcase

        if (use_event)
        begin
            state_next = er.state;
            stall_next = er.stall_down;
            if (er.kick)
            begin
                wd_run_next   = 1'b1;
                wd_count_next = TIMER_WIDTH'(timeout_reg);
            end
            if (er.start)
            begin
                thresh_next = er.start_up ? SAMPLE_WIDTH'(up_stop_reg)
                                          : SAMPLE_WIDTH'(down_stop_reg);
                blank_next  = TIMER_WIDTH'(inrush_reg);
            end
        end
    end

    // output decode from the updated state
    always_comb
    begin
        unique case (state_next)
            ST_UP_BLANK, ST_UP_CHECK:
            begin
                drive  = DRIVE_UP;
                status = STATUS_UP;
            end
            ST_DN_BLANK, ST_DN_CHECK:
            begin
                drive  = DRIVE_DOWN;
                status = STATUS_DOWN;
            end
            ST_ERROR:
            begin
                drive  = DRIVE_OFF;
                status = stall_next ? STATUS_STALL_DOWN : STATUS_STALL_UP;
            end
            default:
            begin
                drive  = DRIVE_OFF;
                status = STATUS_IDLE;
            end
        endcase
        check_on = (state_next == ST_UP_CHECK) || (state_next == ST_DN_CHECK);
        out_data_next = {3'b000, fired, reply, THRESH_W'(thresh_next), check_on,
                         status, drive};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stall_reg     <= 1'b0;
            wd_count_reg  <= '0;
            wd_run_reg    <= 1'b0;
            blank_reg     <= '0;
            thresh_reg    <= SAMPLE_WIDTH'(UP_STOP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg    <= state_next;
                stall_reg    <= stall_next;
                wd_count_reg <= wd_count_next;
                wd_run_reg   <= wd_run_next;
                blank_reg    <= blank_next;
                thresh_reg   <= thresh_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    // a held result blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while result stalled");

    // the watchdog never stops once started
    assert property (@(posedge clk) disable iff (!rst_n)
        wd_run_reg |=> wd_run_reg)
        else $error("watchdog stopped running");

    // an expired watchdog always leaves the actuator idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[4:2] == STATUS_IDLE))
        else $error("timeout without idle status");

    // current checking only while the motor is driven
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[1:0] != DRIVE_OFF))
        else $error("current check on with motor off");

endmodule
